// File: design/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FQD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fqd assertion failed");

// next-cycle implication
`define FQD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fqd assertion failed");

`endif

// File: design/fqd_pkg.sv
// types and codes shared by the tag queue modules
package fqd_pkg;

    localparam int ACTION_W = 2;
    localparam int STATUS_W = 3;
    localparam int PORT_TAG_W = 32;
    localparam int PORT_FILL_W = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ENQ = 2'd0,
        ACT_DEQ = 2'd1,
        ACT_DEL = 2'd2,
        ACT_NOP = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_ZERO     = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_WALK = 1'b1
    } t_state;

    typedef struct packed {
        logic start_walk;
        logic more;
        logic last;
    } t_fsm_in;

    typedef struct packed {
        logic busy;
        logic issue;
    } t_fsm_out;

endpackage

// File: design/fifo_queue_with_delete.sv
// top level of the bounded tag queue with delete by value
//
// A request is taken on a rising edge with start high and busy low:
// i_action selects enqueue, dequeue or delete, i_tag_in carries the tag.
// Exactly one result follows per request, shown for one cycle with o_done
// high: o_status, o_tag_out (the dequeued tag, else zero) and o_fill_count
// (queue length after the request). The receiver cannot stall results.
// Enqueue, refused requests and the unused action code answer in the cycle
// after acceptance and leave busy low, so they may follow back to back.
// Dequeue and delete walk the stored entries through the ram read port,
// one entry per cycle, closing the gap through the write port as they go:
// busy stays high until the last stored entry has been compared, and the
// result is shown in the cycle in which busy falls.
// Reset clears the length and the control state; ram contents need none.
module fifo_queue_with_delete import fqd_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int TAG_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [ACTION_W-1:0]    i_action,
    input  logic [PORT_TAG_W-1:0]  i_tag_in,
    output logic                   o_done,
    output logic [STATUS_W-1:0]    o_status,
    output logic [PORT_TAG_W-1:0]  o_tag_out,
    output logic [PORT_FILL_W-1:0] o_fill_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]        r_occ, n_occ;
    logic                 r_done, n_done;
    t_status              r_status, n_status;
    logic [TAG_WIDTH-1:0] r_tag_out, n_tag_out;
    logic [TAG_WIDTH-1:0] r_tag, n_tag;
    logic                 r_is_deq, n_is_deq;
    logic [CW-1:0]        r_rd_idx, n_rd_idx;
    logic                 r_dv, n_dv;
    logic [AW-1:0]        r_dv_idx, n_dv_idx;
    logic                 r_found, n_found;

    logic [TAG_WIDTH-1:0] w_tag;
    logic [TAG_WIDTH-1:0] w_rdata;
    t_action              w_act;
    logic                 w_accept;
    logic                 w_tag_zero;
    logic                 w_empty;
    logic                 w_full;
    logic                 w_walk_req;
    logic                 w_enq_ok;
    logic                 w_hit;
    logic                 w_shift_wr;
    logic                 w_last;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [TAG_WIDTH-1:0] w_wdata;
    t_fsm_in              w_fsm_in;
    t_fsm_out             w_fsm_out;

    assign w_tag      = TAG_WIDTH'(i_tag_in);
    assign w_act      = t_action'(i_action);
    assign w_accept   = start && !busy;
    assign w_tag_zero = (w_tag == '0);
    assign w_empty    = (r_occ == '0);
    assign w_full     = (r_occ >= CW'(DEPTH));

    assign w_walk_req = w_accept && !w_empty
                        && ((w_act == ACT_DEQ) || ((w_act == ACT_DEL) && !w_tag_zero));
    assign w_enq_ok   = w_accept && (w_act == ACT_ENQ) && !w_tag_zero && !w_full;

    assign w_hit      = r_dv && !r_found
                        && (r_is_deq ? (r_dv_idx == '0) : (w_rdata == r_tag));
    assign w_shift_wr = r_dv && r_found;
    assign w_last     = w_fsm_out.busy && r_dv && (CW'(r_dv_idx) == r_occ - CW'(1));

    assign w_fsm_in.start_walk = w_walk_req;
    assign w_fsm_in.more       = (r_rd_idx < r_occ);
    assign w_fsm_in.last       = w_last;

    fqd_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_fsm_in),
        .o_ctl   (w_fsm_out)
    );

    assign w_we    = w_enq_ok || w_shift_wr;
    assign w_waddr = w_enq_ok ? r_occ[AW-1:0] : (r_dv_idx - AW'(1));
    assign w_wdata = w_enq_ok ? w_tag : w_rdata;

    fqd_ram #(
        .WIDTH (TAG_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_fsm_out.issue),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_occ     = r_occ;
        n_done    = 1'b0;
        n_status  = r_status;
        n_tag_out = r_tag_out;
        n_tag     = r_tag;
        n_is_deq  = r_is_deq;
        n_rd_idx  = r_rd_idx;
        n_dv      = 1'b0;
        n_dv_idx  = r_dv_idx;
        n_found   = r_found;
        if (w_accept) begin
            n_done    = !w_walk_req;
            n_status  = ST_OK;
            n_tag_out = '0;
            n_tag     = w_tag;
            n_is_deq  = (w_act == ACT_DEQ);
            n_rd_idx  = '0;
            n_found   = 1'b0;
            case (w_act)
                ACT_ENQ: begin
                    if (w_tag_zero) begin
                        n_status = ST_ZERO;
                    end else if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_occ = r_occ + CW'(1);
                    end
                end
                ACT_DEQ: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end
                end
                ACT_DEL: begin
                    if (w_tag_zero) begin
                        n_status = ST_ZERO;
                    end else if (w_empty) begin
                        n_status = ST_EMPTY;
                    end
                end
                default: n_status = ST_OK;
            endcase
        end else if (w_fsm_out.busy) begin
            n_dv     = w_fsm_out.issue;
            n_dv_idx = r_rd_idx[AW-1:0];
            if (w_fsm_out.issue) begin
                n_rd_idx = r_rd_idx + CW'(1);
            end
            if (w_hit) begin
                n_found = 1'b1;
                if (r_is_deq) begin
                    n_tag_out = w_rdata;
                end
            end
            if (w_last) begin
                n_done = 1'b1;
                if (r_found || w_hit) begin
                    n_occ    = r_occ - CW'(1);
                    n_status = ST_OK;
                end else begin
                    n_status = ST_NOTFOUND;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= '0;
            r_done  <= 1'b0;
            r_dv    <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_occ   <= n_occ;
            r_done  <= n_done;
            r_dv    <= n_dv;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_tag_out <= n_tag_out;
        r_tag     <= n_tag;
        r_is_deq  <= n_is_deq;
        r_rd_idx  <= n_rd_idx;
        r_dv_idx  <= n_dv_idx;
    end

    assign busy         = w_fsm_out.busy;
    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_tag_out    = PORT_TAG_W'(r_tag_out);
    assign o_fill_count = PORT_FILL_W'(r_occ);

endmodule

// File: design/fqd_ram.sv
// generic simple dual-port ram with registered read
module fqd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/fqd_fsm.sv
// control state machine for the queue walk
module fqd_fsm import fqd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_fsm_in  i_ctl,
    output t_fsm_out o_ctl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_ctl.start_walk) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (i_ctl.last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl = '0;
        unique case (r_state)
            S_IDLE: o_ctl = '0;
            S_WALK: begin
                o_ctl.busy  = 1'b1;
                o_ctl.issue = i_ctl.more;
            end
            default: o_ctl = '0;
        endcase
    end

endmodule

// File: design/fqd_checker.sv
// port-level checker for the tag queue, bound to the top level
`include "assert_macros.svh"

module fqd_checker import fqd_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   start,
    input logic                   busy,
    input logic [ACTION_W-1:0]    i_action,
    input logic [PORT_TAG_W-1:0]  i_tag_in,
    input logic                   o_done,
    input logic [STATUS_W-1:0]    o_status,
    input logic [PORT_TAG_W-1:0]  o_tag_out,
    input logic [PORT_FILL_W-1:0] o_fill_count
);

    logic w_enq_req;

    assign w_enq_req = start && !busy && (i_action == ACT_ENQ);

    `FQD_ASSERT_NXT(a_enq_answers_next, i_clk, i_rst_n, w_enq_req, o_done && !busy)

    `FQD_ASSERT_NXT(a_zero_tag_refused, i_clk, i_rst_n, w_enq_req && (i_tag_in == '0), o_done && (o_status == ST_ZERO))

    `FQD_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_done, o_status <= ST_NOTFOUND)

    `FQD_ASSERT_IMP(a_tag_only_on_ok, i_clk, i_rst_n, o_done && (o_tag_out != '0), o_status == ST_OK)

    `FQD_ASSERT_IMP(a_fill_stable_walk, i_clk, i_rst_n, busy && $past(busy), $stable(o_fill_count))

endmodule

bind fifo_queue_with_delete fqd_checker u_fqd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_action     (i_action),
    .i_tag_in     (i_tag_in),
    .o_done       (o_done),
    .o_status     (o_status),
    .o_tag_out    (o_tag_out),
    .o_fill_count (o_fill_count)
);

// File: dv/tb.sv
// self-checking testbench for the tag queue with delete by value
module tb;
    import fqd_pkg::*;

    localparam int QDEPTH = 16;
    localparam int TAG_W = 32;
    localparam int RAND_SEGMENTS = 13;
    localparam int SEGMENT_LEN = 48;
    localparam int STALL_LIMIT = 500;

    typedef struct {
        t_status                status;
        logic [PORT_TAG_W-1:0]  tag;
        logic [PORT_FILL_W-1:0] fill;
    } queue_result_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [ACTION_W-1:0]    i_action = ACT_NOP;
    logic [PORT_TAG_W-1:0]  i_tag_in = '0;
    logic                   o_done;
    logic [STATUS_W-1:0]    o_status;
    logic [PORT_TAG_W-1:0]  o_tag_out;
    logic [PORT_FILL_W-1:0] o_fill_count;

    logic [TAG_W-1:0] queue_contents[$];
    queue_result_t    expected_results[$];
    int               requests_sent = 0;
    int               results_checked = 0;
    int               mismatches = 0;
    int               unexpected_results = 0;
    int               stall_cycles = 0;
    int               status_seen[5] = '{default: 0};

    fifo_queue_with_delete #(
        .DEPTH(QDEPTH),
        .TAG_WIDTH(TAG_W)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_action(i_action),
        .i_tag_in(i_tag_in),
        .o_done(o_done),
        .o_status(o_status),
        .o_tag_out(o_tag_out),
        .o_fill_count(o_fill_count)
    );

    always #1 i_clk = ~i_clk;

    function automatic queue_result_t predict_outcome(t_action act, logic [TAG_W-1:0] tag);
        queue_result_t res;
        int            pos;
        res.status = ST_OK;
        res.tag = '0;
        pos = -1;
        case (act)
            ACT_ENQ: begin
                if (tag == '0) begin
                    res.status = ST_ZERO;
                end else if (queue_contents.size() >= QDEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    queue_contents.push_back(tag);
                end
            end
            ACT_DEQ: begin
                if (queue_contents.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.tag = queue_contents.pop_front();
                end
            end
            ACT_DEL: begin
                if (tag == '0) begin
                    res.status = ST_ZERO;
                end else if (queue_contents.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    for (int i = 0; i < queue_contents.size(); i++) begin
                        if (pos < 0 && queue_contents[i] == tag) pos = i;
                    end
                    if (pos >= 0) queue_contents.delete(pos);
                    else res.status = ST_NOTFOUND;
                end
            end
            default: ;
        endcase
        res.fill = PORT_FILL_W'(queue_contents.size());
        return res;
    endfunction

    // holds start high until the request is taken, then records what it should return
    task automatic send_request(t_action act, logic [PORT_TAG_W-1:0] tag);
        start <= 1'b1;
        i_action <= act;
        i_tag_in <= tag;
        do @(posedge i_clk); while (busy);
        expected_results.push_back(predict_outcome(act, tag[TAG_W-1:0]));
        requests_sent++;
    endtask

    task automatic pause(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic logic [PORT_TAG_W-1:0] pick_tag();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5) return '0;
        if (roll < 35) return PORT_TAG_W'($urandom_range(1, 6));
        if (roll < 45) return '1;
        return $urandom;
    endfunction

    task automatic test_empty_queue();
        send_request(ACT_DEQ, 32'h0000_0005);
        send_request(ACT_DEL, 32'h0000_0005);
        send_request(ACT_DEL, 32'h0000_0000);
        send_request(ACT_ENQ, 32'h0000_0000);
        send_request(ACT_NOP, 32'hFFFF_FFFF);
    endtask

    task automatic test_fill_and_delete();
        send_request(ACT_ENQ, 32'hFFFF_FFFF);
        send_request(ACT_ENQ, 32'h0000_0001);
        send_request(ACT_ENQ, 32'h8000_0000);
        for (int i = 0; i < QDEPTH - 3; i++) send_request(ACT_ENQ, 32'h0000_0010 + (i % 4));
        send_request(ACT_ENQ, 32'h0000_0002);
        send_request(ACT_ENQ, 32'h0000_0000);
        send_request(ACT_NOP, 32'h0000_0000);
        // duplicates: only the first match goes
        send_request(ACT_DEL, 32'h0000_0011);
        send_request(ACT_DEL, 32'h0000_0013);
        send_request(ACT_DEL, 32'h1234_5678);
        send_request(ACT_DEL, 32'hFFFF_FFFF);
        send_request(ACT_DEQ, 32'h0000_0000);
    endtask

    task automatic test_random_traffic();
        int               enq_pct;
        int               roll;
        int               burst_left;
        bit               no_gaps;
        t_action          act;
        logic [PORT_TAG_W-1:0] tag;
        for (int seg = 0; seg < RAND_SEGMENTS; seg++) begin
            // alternate filling and draining so both ends of the queue get exercised
            enq_pct = (seg % 2 == 0) ? 60 : 25;
            no_gaps = (seg % 4 == 3);
            burst_left = $urandom_range(1, 20);
            for (int n = 0; n < SEGMENT_LEN; n++) begin
                roll = $urandom_range(99);
                tag = $urandom;
                if (roll < 4) begin
                    act = ACT_NOP;
                end else if (roll < enq_pct) begin
                    act = ACT_ENQ;
                    tag = pick_tag();
                end else if (roll < enq_pct + (100 - enq_pct) / 2) begin
                    act = ACT_DEQ;
                end else begin
                    act = ACT_DEL;
                    if (queue_contents.size() > 0 && $urandom_range(3) != 0)
                        tag = queue_contents[$urandom_range(queue_contents.size() - 1)];
                    else
                        tag = pick_tag();
                end
                send_request(act, tag);
                if (!no_gaps) begin
                    burst_left--;
                    if (burst_left == 0) begin
                        pause($urandom_range(1, 12));
                        burst_left = $urandom_range(1, 20);
                    end
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        queue_result_t exp_res;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                unexpected_results++;
                $display("unexpected result: status %0d tag %h fill %0d",
                         o_status, o_tag_out, o_fill_count);
            end else begin
                exp_res = expected_results.pop_front();
                results_checked++;
                status_seen[exp_res.status]++;
                if (o_status !== exp_res.status || o_tag_out !== exp_res.tag
                        || o_fill_count !== exp_res.fill) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch %0d: expected status %0d tag %h fill %0d, got status %0d tag %h fill %0d",
                                 results_checked, exp_res.status, exp_res.tag, exp_res.fill,
                                 o_status, o_tag_out, o_fill_count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("fifo_queue_with_delete regression: fail");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_queue();
        test_fill_and_delete();
        test_random_traffic();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (QDEPTH + 4) @(posedge i_clk);
        $display("%0d requests sent, %0d results checked, %0d mismatches, %0d unexpected",
                 requests_sent, results_checked, mismatches, unexpected_results);
        $display("outcomes: ok %0d, empty %0d, full %0d, zero tag %0d, not found %0d",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
                 status_seen[ST_ZERO], status_seen[ST_NOTFOUND]);
        if (mismatches == 0 && unexpected_results == 0 && expected_results.size() == 0) begin
            $display("fifo_queue_with_delete regression: pass");
        end else begin
            $display("fifo_queue_with_delete regression: fail");
        end
        $finish;
    end

endmodule
